/* rtl/core/dssed_pkg.sv */
// ----------------------------------------------------------------------------
// dssed_pkg
// Shared widths, types and register codes of the DoG extrema detector.
// ----------------------------------------------------------------------------
package dssed_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int NUM_LAYERS    = 3;
   localparam int THR_BITS      = 15;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 13;
   localparam int OCT_BITS      = 4;
   localparam int LAYER_BITS    = 3;
   localparam int ROW_BITS      = 12;
   localparam int COL_OUT_BITS  = 10;
   localparam int DIM_BITS      = 14;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 15;
   localparam int MIN_DIM       = 3;
   localparam int MAX_HEIGHT    = 4096;
   localparam int FIRST_INNER   = 2;

   localparam logic [THR_BITS-1:0]   THR_RESET    = THR_BITS'(256);
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(768);
   localparam logic [OCT_BITS-1:0]   OCT_RESET    = '0;
   localparam logic [LAYER_BITS-1:0] LAYER_RESET  = LAYER_BITS'(1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_WIDTH     = 3'd1,
      CSR_HEIGHT    = 3'd2,
      CSR_OCTAVE    = 3'd3,
      CSR_LAYER     = 3'd4
   } csr_idx_type;

   // position of the pixel just taken in
   typedef struct packed {
      logic                interior;
      logic [ROW_BITS-1:0] row;
   } pos_type;

endpackage

/* rtl/core/dssed_if.sv */
// ----------------------------------------------------------------------------
// dssed_req_if / dssed_rsp_if
// Valid/ready channels for pixel requests and detection results.
// ----------------------------------------------------------------------------
interface dssed_req_if import dssed_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type below_sample;
   sample_type centre_sample;
   sample_type above_sample;
   logic       frame_start;

   modport source (output valid, below_sample, centre_sample, above_sample, frame_start,
                   input ready);
   modport sink   (input valid, below_sample, centre_sample, above_sample, frame_start,
                   output ready);
endinterface

interface dssed_rsp_if import dssed_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    window_valid;
   logic                    is_extremum;
   logic [ROW_BITS-1:0]     centre_row;
   logic [COL_OUT_BITS-1:0] centre_col;
   logic [OCT_BITS-1:0]     octave_out;
   logic [LAYER_BITS-1:0]   layer_out;

   modport source (output valid, window_valid, is_extremum, centre_row, centre_col,
                   octave_out, layer_out, input ready);
   modport sink   (input valid, window_valid, is_extremum, centre_row, centre_col,
                   octave_out, layer_out, output ready);
endinterface

/* rtl/core/dssed_ram.sv */
// ----------------------------------------------------------------------------
// dssed_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dssed_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dssed_pos.sv */
// ----------------------------------------------------------------------------
// dssed_pos
// Raster position counters with width/height clamping and frame restart.
// ----------------------------------------------------------------------------
module dssed_pos import dssed_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         frame_start,
   input  logic [WIDTH_BITS-1:0]        image_width,
   input  logic [HEIGHT_BITS-1:0]       image_height,
   output logic [$clog2(MAX_WIDTH)-1:0] cur_col,
   output pos_type                      cur_pos
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [COL_BITS-1:0] col_ff, col_in, col_start, col_cur;
   logic [ROW_BITS-1:0] row_ff, row_in, row_start, row_cur;
   logic [DIM_BITS-1:0] w_raw, h_raw, w_eff, h_eff, col_inc, row_inc;

   always_comb begin
      w_raw = DIM_BITS'(image_width);
      h_raw = DIM_BITS'(image_height);
      if (w_raw < DIM_BITS'(MIN_DIM)) begin
         w_eff = DIM_BITS'(MIN_DIM);
      end else if (w_raw > DIM_BITS'(MAX_WIDTH)) begin
         w_eff = DIM_BITS'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < DIM_BITS'(MIN_DIM)) begin
         h_eff = DIM_BITS'(MIN_DIM);
      end else if (h_raw > DIM_BITS'(MAX_HEIGHT)) begin
         h_eff = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end

      col_start = frame_start ? '0 : col_ff;
      row_start = frame_start ? '0 : row_ff;
      col_cur   = (DIM_BITS'(col_start) >= w_eff) ? '0 : col_start;
      row_cur   = (DIM_BITS'(row_start) >= h_eff) ? '0 : row_start;

      col_inc = DIM_BITS'(col_cur) + DIM_BITS'(1);
      row_inc = DIM_BITS'(row_cur) + DIM_BITS'(1);
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
         col_in = col_inc[COL_BITS-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_col          = col_cur;
   assign cur_pos.row      = row_cur;
   assign cur_pos.interior = (row_cur >= ROW_BITS'(FIRST_INNER)) &&
                             (col_cur >= COL_BITS'(FIRST_INNER));

endmodule

/* rtl/core/dssed_window.sv */
// ----------------------------------------------------------------------------
// dssed_window
// 3x3x3 window registers and the 26-neighbour max/min test on the new window.
// ----------------------------------------------------------------------------
module dssed_window import dssed_pkg::*; (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   shift_en,
   input  logic [2*NUM_LAYERS*SAMPLE_BITS-1:0]    line_data,
   input  logic [NUM_LAYERS*SAMPLE_BITS-1:0]      fresh,
   input  logic [THR_BITS-1:0]                    threshold,
   output logic                                   is_peak
);

   localparam int HALF = NUM_LAYERS * SAMPLE_BITS;

   // [layer][row: 0 oldest][col: 0 oldest]
   sample_type win_ff [NUM_LAYERS][3][3];
   sample_type win_in [NUM_LAYERS][3][3];

   sample_type                px;
   logic signed [SAMPLE_BITS:0] px_wide;
   logic [SAMPLE_BITS:0]      mag;
   logic                      ge, le;

   always_comb begin
      for (int l = 0; l < NUM_LAYERS; l++) begin
         for (int r = 0; r < 3; r++) begin
            win_in[l][r][0] = win_ff[l][r][1];
            win_in[l][r][1] = win_ff[l][r][2];
         end
         win_in[l][0][2] = sample_type'(line_data[HALF + l*SAMPLE_BITS +: SAMPLE_BITS]);
         win_in[l][1][2] = sample_type'(line_data[l*SAMPLE_BITS +: SAMPLE_BITS]);
         win_in[l][2][2] = sample_type'(fresh[l*SAMPLE_BITS +: SAMPLE_BITS]);
      end
   end

   always_comb begin
      px      = win_in[1][1][1];
      px_wide = {px[SAMPLE_BITS-1], px};
      mag     = px[SAMPLE_BITS-1] ? -px_wide : px_wide;
      ge      = 1'b1;
      le      = 1'b1;
      for (int l = 0; l < NUM_LAYERS; l++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (!(l == 1 && r == 1 && c == 1)) begin
                  if (px < win_in[l][r][c]) ge = 1'b0;
                  if (px > win_in[l][r][c]) le = 1'b0;
               end
            end
         end
      end
      is_peak = (mag >= (SAMPLE_BITS+1)'(threshold)) && (ge || le);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LAYERS; l++) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  win_ff[l][r][c] <= '0;
               end
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

/* rtl/core/dog_scale_space_extrema_detect.sv */
// Pipeline: an accepted request passes stage 1, then the result register.
// Throughput: one request per cycle while results are taken; the line store
// is one RAM with one read and one write port, read at accept and written
// when stage 1 fires. Stall on the result side holds the pipeline; a request
// is still taken while a result waits, if stage 1 is empty or can move.
// Sync reset: clears counters, window and pipeline valids, presets the CSRs.
// ----------------------------------------------------------------------------
// dog_scale_space_extrema_detect
// 3x3x3 scale-space extremum detector over three DoG layers in raster order.
// ----------------------------------------------------------------------------
module dog_scale_space_extrema_detect import dssed_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   dssed_req_if.sink                req_if,
   dssed_rsp_if.source              rsp_if,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int HALF      = NUM_LAYERS * SAMPLE_BITS;
   localparam int LINE_BITS = 2 * HALF;

   // configuration
   logic [THR_BITS-1:0]    thr_ff;
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [OCT_BITS-1:0]    octave_ff;
   logic [LAYER_BITS-1:0]  layer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         octave_ff <= OCT_RESET;
         layer_ff  <= LAYER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_THRESHOLD: thr_ff    <= csr_wr_data[THR_BITS-1:0];
            CSR_WIDTH:     width_ff  <= csr_wr_data[WIDTH_BITS-1:0];
            CSR_HEIGHT:    height_ff <= csr_wr_data[HEIGHT_BITS-1:0];
            CSR_OCTAVE:    octave_ff <= csr_wr_data[OCT_BITS-1:0];
            CSR_LAYER:     layer_ff  <= csr_wr_data[LAYER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic accept, s1_fire;
   logic s1_vld_ff, rsp_vld_ff;

   assign s1_fire      = s1_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s1_vld_ff || s1_fire;
   assign accept       = req_if.valid && req_if.ready;

   // position
   logic [COL_BITS-1:0] cur_col;
   pos_type             cur_pos;

   dssed_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_start  (req_if.frame_start),
      .image_width  (width_ff),
      .image_height (height_ff),
      .cur_col      (cur_col),
      .cur_pos      (cur_pos)
   );

   // stage 1: line store read in flight
   logic [COL_BITS-1:0]  s1_col_ff;
   pos_type              s1_pos_ff;
   logic [HALF-1:0]      s1_fresh_ff;
   logic                 byp_ff;
   logic [LINE_BITS-1:0] byp_data_ff;
   logic [LINE_BITS-1:0] ram_rd_data, line_data, wr_data;

   assign line_data = byp_ff ? byp_data_ff : ram_rd_data;
   // row above moves to two-above, fresh pixels become row above
   assign wr_data   = {line_data[HALF-1:0], s1_fresh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (accept) begin
            s1_vld_ff <= 1'b1;
            // same column written this cycle: RAM read returns stale data
            byp_ff    <= s1_fire && (s1_col_ff == cur_col);
         end else if (s1_fire) begin
            s1_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_pos_ff   <= cur_pos;
         s1_fresh_ff <= {req_if.above_sample, req_if.centre_sample, req_if.below_sample};
         byp_data_ff <= wr_data;
      end
   end

   dssed_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   logic is_peak;

   dssed_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_fire),
      .line_data (line_data),
      .fresh     (s1_fresh_ff),
      .threshold (thr_ff),
      .is_peak   (is_peak)
   );

   // result register
   logic                    win_valid_ff, extremum_ff;
   logic [ROW_BITS-1:0]     row_ff;
   logic [COL_OUT_BITS-1:0] col_ff;
   logic [OCT_BITS-1:0]     oct_out_ff;
   logic [LAYER_BITS-1:0]   layer_out_ff;
   logic [COL_BITS-1:0]     centre_col_full;

   assign centre_col_full = s1_col_ff - COL_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_valid_ff <= s1_pos_ff.interior;
         extremum_ff  <= s1_pos_ff.interior && is_peak;
         row_ff       <= s1_pos_ff.interior ? s1_pos_ff.row - ROW_BITS'(1) : '0;
         col_ff       <= s1_pos_ff.interior ? COL_OUT_BITS'(centre_col_full) : '0;
         oct_out_ff   <= octave_ff;
         layer_out_ff <= layer_ff;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.window_valid = win_valid_ff;
   assign rsp_if.is_extremum  = extremum_ff;
   assign rsp_if.centre_row   = row_ff;
   assign rsp_if.centre_col   = col_ff;
   assign rsp_if.octave_out   = oct_out_ff;
   assign rsp_if.layer_out    = layer_out_ff;

   // checks
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_vld_ff || s1_fire))
      else $error("request accepted over a held stage-1 entry");

   a_ext_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && extremum_ff) |-> win_valid_ff)
      else $error("extremum flagged on a border pixel");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !win_valid_ff) |-> (row_ff == '0 && col_ff == '0))
      else $error("border result carries a position");

   a_bypass_col: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_fire && (s1_col_ff == cur_col)) |=> byp_ff)
      else $error("line store bypass missed");

endmodule

/* tb/dssed_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dssed_result_checker
// Watches the pixel request, result and register ports of the DoG extrema
// detector. Keeps its own line stores, 3x3x3 cube and raster counters,
// predicts one detection per accepted request and compares every accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dssed_result_checker import dssed_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   dssed_req_if                     req_mon,
   dssed_rsp_if                     rsp_mon,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data,
   output int                       pending_count,
   output int                       error_count
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic                    window_valid;
      logic                    is_extremum;
      logic [ROW_BITS-1:0]     centre_row;
      logic [COL_OUT_BITS-1:0] centre_col;
      logic [OCT_BITS-1:0]     octave_out;
      logic [LAYER_BITS-1:0]   layer_out;
   } detection_type;

   logic [THR_BITS-1:0]     cfg_threshold;
   logic [WIDTH_BITS-1:0]   cfg_width;
   logic [HEIGHT_BITS-1:0]  cfg_height;
   logic [OCT_BITS-1:0]     cfg_octave;
   logic [LAYER_BITS-1:0]   cfg_layer;

   sample_type              line_one [MAX_WIDTH][NUM_LAYERS];
   sample_type              line_two [MAX_WIDTH][NUM_LAYERS];
   sample_type              cube [NUM_LAYERS][3][3];   // [layer][row][col], index 0 oldest
   logic [ROW_BITS-1:0]     row_count;
   logic [COL_OUT_BITS-1:0] col_count;

   detection_type           expected_detections [$];
   int                      result_index;

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                result_index, name, got, want));
      end
   endtask

   task automatic predict_detection(input sample_type below, centre, above,
                                    input logic frame_start, output detection_type res);
      int unsigned eff_w;
      int unsigned eff_h;
      int unsigned row;
      int unsigned col;
      sample_type  fresh [NUM_LAYERS];
      int          peak;
      int          mag;
      logic        hi_ok;
      logic        lo_ok;
      logic        valid;
      fresh[0] = below;
      fresh[1] = centre;
      fresh[2] = above;
      eff_w = (cfg_width < MIN_DIM) ? MIN_DIM : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      eff_h = (cfg_height < MIN_DIM) ? MIN_DIM :
              ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
      if (frame_start) begin
         row_count = '0;
         col_count = '0;
      end
      row = row_count;
      col = col_count;
      // a counter left beyond a shrunken frame restarts at zero
      if (col >= eff_w) col = 0;
      if (row >= eff_h) row = 0;

      for (int l = 0; l < NUM_LAYERS; l++) begin
         for (int r = 0; r < 3; r++) begin
            cube[l][r][0] = cube[l][r][1];
            cube[l][r][1] = cube[l][r][2];
         end
         cube[l][0][2]  = line_two[col][l];
         cube[l][1][2]  = line_one[col][l];
         cube[l][2][2]  = fresh[l];
         line_two[col][l] = line_one[col][l];
         line_one[col][l] = fresh[l];
      end

      valid = (row >= FIRST_INNER) && (col >= FIRST_INNER);
      peak  = cube[1][1][1];
      mag   = (peak < 0) ? -peak : peak;
      hi_ok = 1'b1;
      lo_ok = 1'b1;
      for (int l = 0; l < NUM_LAYERS; l++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               if (!(l == 1 && r == 1 && k == 1)) begin
                  if (peak < cube[l][r][k]) hi_ok = 1'b0;
                  if (peak > cube[l][r][k]) lo_ok = 1'b0;
               end
            end
         end
      end

      res.window_valid = valid;
      res.is_extremum  = valid && (mag >= int'(cfg_threshold)) && (hi_ok || lo_ok);
      res.centre_row   = valid ? ROW_BITS'(row - 1) : '0;
      res.centre_col   = valid ? COL_OUT_BITS'(col - 1) : '0;
      res.octave_out   = cfg_octave;
      res.layer_out    = cfg_layer;

      col++;
      if (col >= eff_w) begin
         col = 0;
         row++;
         if (row >= eff_h) row = 0;
      end
      col_count = COL_OUT_BITS'(col);
      row_count = ROW_BITS'(row);
   endtask

   always @(posedge clock) begin : monitor
      detection_type want;
      detection_type got;
      if (reset) begin
         cfg_threshold = THR_RESET;
         cfg_width     = WIDTH_RESET;
         cfg_height    = HEIGHT_RESET;
         cfg_octave    = OCT_RESET;
         cfg_layer     = LAYER_RESET;
         for (int c = 0; c < MAX_WIDTH; c++) begin
            for (int l = 0; l < NUM_LAYERS; l++) begin
               line_one[c][l] = '0;
               line_two[c][l] = '0;
            end
         end
         for (int l = 0; l < NUM_LAYERS; l++) begin
            for (int r = 0; r < 3; r++) begin
               for (int k = 0; k < 3; k++) cube[l][r][k] = '0;
            end
         end
         row_count = '0;
         col_count = '0;
         expected_detections.delete();
         result_index = 0;
         error_count  = 0;
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_THRESHOLD: cfg_threshold = csr_wr_data[THR_BITS-1:0];
               CSR_WIDTH:     cfg_width     = csr_wr_data[WIDTH_BITS-1:0];
               CSR_HEIGHT:    cfg_height    = csr_wr_data[HEIGHT_BITS-1:0];
               CSR_OCTAVE:    cfg_octave    = csr_wr_data[OCT_BITS-1:0];
               CSR_LAYER:     cfg_layer     = csr_wr_data[LAYER_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.window_valid = rsp_mon.window_valid;
            got.is_extremum  = rsp_mon.is_extremum;
            got.centre_row   = rsp_mon.centre_row;
            got.centre_col   = rsp_mon.centre_col;
            got.octave_out   = rsp_mon.octave_out;
            got.layer_out    = rsp_mon.layer_out;
            if (expected_detections.size() == 0) begin
               report_error($sformatf("result %0d arrived with no request pending",
                                      result_index));
            end else begin
               want = expected_detections.pop_front();
               check_field("window_valid", 16'(got.window_valid), 16'(want.window_valid));
               check_field("is_extremum",  16'(got.is_extremum),  16'(want.is_extremum));
               check_field("centre_row",   16'(got.centre_row),   16'(want.centre_row));
               check_field("centre_col",   16'(got.centre_col),   16'(want.centre_col));
               check_field("octave_out",   16'(got.octave_out),   16'(want.octave_out));
               check_field("layer_out",    16'(got.layer_out),    16'(want.layer_out));
            end
            result_index++;
         end

         if (req_mon.valid && req_mon.ready) begin
            predict_detection(req_mon.below_sample, req_mon.centre_sample,
                              req_mon.above_sample, req_mon.frame_start, want);
            expected_detections = {expected_detections, want};
         end

         pending_count <= expected_detections.size();
      end
   end

endmodule

/* tb/dog_scale_space_extrema_detect_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dog_scale_space_extrema_detect_test
// Top of the extrema detector test. Drives pixel requests in phases: reset
// settings, hand-built 3x3 frames with a single peak, trough or flat field,
// then random pixels over fixed and random register settings, with random
// gaps on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module dog_scale_space_extrema_detect_test;
   import dssed_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int BURST_SPAN   = 40;

   typedef enum int {
      PIX_FULL,
      PIX_FLAT,
      PIX_SPIKE
   } pixel_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wr_data;
   int                       pending_count;
   int                       error_count;
   int                       cycle_count = 0;
   int                       req_sent    = 0;
   int                       rsp_taken   = 0;
   logic                     req_quiet   = 1'b0;
   logic                     rsp_quiet   = 1'b0;
   logic [WIDTH_BITS-1:0]    last_width;

   dssed_req_if req_if ();
   dssed_rsp_if rsp_if ();

   dog_scale_space_extrema_detect u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dssed_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls, with stretches of none
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_taken % BURST_SPAN == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         gap = rsp_quiet ? 0 : $urandom_range(0, 4);
         rsp_taken++;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_pixel(input sample_type below, centre, above, input logic start);
      int gap;
      if (req_sent % BURST_SPAN == 0) req_quiet = ($urandom_range(0, 3) == 0);
      gap = req_quiet ? 0 : $urandom_range(0, 4);
      req_sent++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.below_sample  <= below;
      req_if.centre_sample <= centre;
      req_if.above_sample  <= above;
      req_if.frame_start   <= start;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // hold requests off until every outstanding request has its result
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_BITS-1:0] thr, wid, hgt, oct, lay);
      logic [CSR_DATA_BITS-1:0] values [5];
      csr_idx_type              regs [5];
      values = '{thr, wid, hgt, oct, lay};
      regs   = '{CSR_THRESHOLD, CSR_WIDTH, CSR_HEIGHT, CSR_OCTAVE, CSR_LAYER};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= regs[i];
         csr_wr_data <= values[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic draw_pixel(input pixel_mode_type mode, output sample_type below, centre, above);
      int mag;
      case (mode)
         PIX_FULL: begin
            below  = sample_type'($urandom);
            centre = sample_type'($urandom);
            above  = sample_type'($urandom);
         end
         PIX_FLAT: begin
            // narrow value set: ties and plateaus are common
            below  = sample_type'(int'($urandom_range(0, 16)) - 8);
            centre = sample_type'(int'($urandom_range(0, 16)) - 8);
            above  = sample_type'(int'($urandom_range(0, 16)) - 8);
         end
         default: begin
            below  = sample_type'(int'($urandom_range(0, 64)) - 32);
            centre = sample_type'(int'($urandom_range(0, 64)) - 32);
            above  = sample_type'(int'($urandom_range(0, 64)) - 32);
            if ($urandom_range(0, 9) == 0) begin
               mag = $urandom_range(200, 32767);
               if ($urandom_range(0, 3) == 0) centre = 16'sh8000;
               else centre = sample_type'($urandom_range(0, 1) ? mag : -mag);
            end
            // spike in an outer layer can spoil a nearby peak
            if ($urandom_range(0, 29) == 0) below = sample_type'($urandom);
            if ($urandom_range(0, 29) == 0) above = sample_type'($urandom);
         end
      endcase
   endtask

   task automatic run_phase(input logic [CSR_DATA_BITS-1:0] thr, wid, hgt, oct, lay,
                            input pixel_mode_type mode, input int count, input int pause_at);
      sample_type below;
      sample_type centre;
      sample_type above;
      logic       start;
      logic       new_width;
      drain_results();
      new_width = (wid[WIDTH_BITS-1:0] != last_width);
      write_registers(thr, wid, hgt, oct, lay);
      last_width = wid[WIDTH_BITS-1:0];
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) drain_results();
         draw_pixel(mode, below, centre, above);
         // a wider line must be refilled from a frame start before rows are used
         start = (i == 0 && new_width) || ($urandom_range(0, 49) == 0);
         send_pixel(below, centre, above, start);
      end
   endtask

   initial begin
      sample_type               peak [3];
      sample_type               other [3];
      sample_type               below;
      sample_type               centre;
      sample_type               above;
      logic [CSR_DATA_BITS-1:0] rnd_thr;
      logic [CSR_DATA_BITS-1:0] rnd_wid;
      logic [CSR_DATA_BITS-1:0] rnd_hgt;

      req_if.valid         <= 1'b0;
      req_if.below_sample  <= '0;
      req_if.centre_sample <= '0;
      req_if.above_sample  <= '0;
      req_if.frame_start   <= 1'b0;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_THRESHOLD;
      csr_wr_data          <= '0;
      last_width = WIDTH_RESET;
      do @(posedge clock); while (reset);

      // a few requests under the reset settings
      for (int i = 0; i < 4; i++) begin
         draw_pixel(PIX_FULL, below, centre, above);
         send_pixel(below, centre, above, i == 0);
      end

      // 3x3 frames: lone maximum, lone minimum, flat field below threshold;
      // the later frames start by row wrap alone
      peak  = '{16'sh7FFF, 16'sh8000, 16'sh0000};
      other = '{16'sh8000, 16'sh7FFF, 16'sh0000};
      drain_results();
      write_registers(15'd32767, 15'd3, 15'd3, 15'd5, 15'd6);
      last_width = WIDTH_BITS'(3);
      for (int f = 0; f < 3; f++) begin
         for (int p = 0; p < 9; p++) begin
            send_pixel(other[f], (p == 4) ? peak[f] : other[f], other[f], f == 0 && p == 0);
         end
      end

      run_phase(15'd0,     15'd0,    15'd0,    15'd15, 15'd0, PIX_FLAT,  40,  -1);
      run_phase(15'd32767, 15'd5,    15'd4,    15'd7,  15'd7, PIX_FULL,  40,  -1);
      run_phase(15'd2,     15'd8,    15'd6,    15'd3,  15'd6, PIX_FLAT,  60,  30);
      run_phase(15'd300,   15'd16,   15'd8191, 15'd9,  15'd2, PIX_SPIKE, 100, -1);
      run_phase(15'd1,     15'd2047, 15'd3,    15'd12, 15'd5, PIX_FLAT,  60,  -1);
      run_phase(15'd128,   15'd7,    15'd5,    15'd1,  15'd3, PIX_SPIKE, 60,  -1);
      run_phase(15'd0,     15'd4,    15'd4096, 15'd0,  15'd4, PIX_FLAT,  30,  -1);

      for (int k = 0; k < 4; k++) begin
         rnd_wid = ($urandom_range(0, 9) == 0) ? CSR_DATA_BITS'($urandom_range(0, 2)) :
                                                 CSR_DATA_BITS'($urandom_range(3, 12));
         rnd_hgt = ($urandom_range(0, 9) == 0) ? CSR_DATA_BITS'($urandom_range(0, 2)) :
                                                 CSR_DATA_BITS'($urandom_range(3, 9));
         rnd_thr = ($urandom_range(0, 3) == 0) ? CSR_DATA_BITS'($urandom_range(0, 32767)) :
                                                 CSR_DATA_BITS'($urandom_range(0, 20));
         // octave and layer writes carry junk in the unused upper bits
         run_phase(rnd_thr, rnd_wid, rnd_hgt, CSR_DATA_BITS'($urandom),
                   CSR_DATA_BITS'($urandom), pixel_mode_type'($urandom_range(0, 2)),
                   30, $urandom_range(5, 25));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
